[rtl/cdtq_pkg.sv]
// Shared types and constants of the dual CAN transmit queue with mailbox dispatch.
`default_nettype none

package cdtq_pkg;

  localparam int unsigned QueueDepthDefault = 16;

  localparam logic [11:0] StdIdMax = 12'h7FF;
  localparam logic [3:0]  DlcMax   = 4'd8;
  localparam logic [15:0] CountMax = 16'hFFFF;

  typedef enum logic [2:0] {
    STATUS_QUEUED   = 3'd0,
    STATUS_REJECTED = 3'd1,
    STATUS_SENT     = 3'd2,
    STATUS_NULL     = 3'd3,
    STATUS_BUSY     = 3'd4,
    STATUS_EMPTY    = 3'd5
  } status_e;

  typedef enum logic {
    OP_ENQUEUE = 1'b0,
    OP_DRAIN   = 1'b1
  } op_e;

  // Queue entry: header fields and the two data words.
  typedef struct packed {
    logic [3:0]  dlc;
    logic        rtr;
    logic        ide;
    logic [28:0] ext_id;
    logic [10:0] std_id;
    logic [31:0] data_hi;
    logic [31:0] data_lo;
  } entry_t;

  typedef struct packed {
    logic accept;  // request taken this cycle
    logic finish;  // queue head read data valid, complete the drain
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_drain;  // offered request is a drain
    logic in_empty;  // queue named by the offered drain is empty
  } dp_stat_t;

endpackage

`default_nettype wire

[rtl/can_dual_tx_queue_mailbox_dispatch_unit.sv]
// Top level: dual CAN transmit queue with lowest-free mailbox dispatch.
// Usage:
//   Slave stream carries one request: tuser is the op (enqueue or drain),
//   tdata the queue target, the message fields and the mailbox free flags.
//   Master stream returns one result per request: tuser is the status,
//   tdata the mailbox, the packed mailbox words and the overflow state.
// Results: an enqueue or a drain of an empty queue shows its result in the
//   cycle after acceptance; any other drain passes through the READ state
//   first, for the registered read of the port's queue memory.
// Flow: one request in flight; each request passes the controller's accept
//   and result states, and a drain of a non-empty queue its memory read state.
// Reset: pointers, overflow flags and counts clear at once; queue memory
//   is not cleared, entries are only read after being written.
// Stall: while a result waits for m_axis_tready it is held stable and no
//   new request is taken.
`default_nettype none

module can_dual_tx_queue_mailbox_dispatch_unit #(
  parameter int unsigned QUEUE_DEPTH = cdtq_pkg::QueueDepthDefault
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  // port_mask, drain_port, std_id, ext_id, is_ext, is_remote, length,
  // payload_low, payload_high, mailbox_free, zero fill
  input  wire  [119:0] s_axis_tdata,
  // op
  input  wire          s_axis_tuser,
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  // mailbox, id_word, length_word, data_low_word, data_high_word,
  // overflow_flag, overflow_total
  output logic [119:0] m_axis_tdata,
  // status
  output logic [2:0]   m_axis_tuser
);

  cdtq_pkg::ctrl_cmd_t cmd;
  cdtq_pkg::dp_stat_t  stat;

  logic [1:0]  mailbox;
  logic [31:0] id_word;
  logic [3:0]  length_word;
  logic [31:0] data_low_word;
  logic [31:0] data_high_word;
  logic [1:0]  overflow_flag;
  logic [15:0] overflow_total;

  cdtq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  cdtq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .op_i             (s_axis_tuser),
    .port_mask_i      (s_axis_tdata[1:0]),
    .drain_port_i     (s_axis_tdata[2]),
    .std_id_i         (s_axis_tdata[14:3]),
    .ext_id_i         (s_axis_tdata[43:15]),
    .is_ext_i         (s_axis_tdata[44]),
    .is_remote_i      (s_axis_tdata[45]),
    .length_i         (s_axis_tdata[49:46]),
    .payload_low_i    (s_axis_tdata[81:50]),
    .payload_high_i   (s_axis_tdata[113:82]),
    .mailbox_free_i   (s_axis_tdata[116:114]),
    .status_o         (m_axis_tuser),
    .mailbox_o        (mailbox),
    .id_word_o        (id_word),
    .length_word_o    (length_word),
    .data_low_word_o  (data_low_word),
    .data_high_word_o (data_high_word),
    .overflow_flag_o  (overflow_flag),
    .overflow_total_o (overflow_total)
  );

  assign m_axis_tdata = {overflow_total, overflow_flag, data_high_word, data_low_word,
                         length_word, id_word, mailbox};

endmodule

`default_nettype wire

[rtl/cdtq_datapath.sv]
// Datapath: per-port ring memories, pointers, overflow tracking and result registers.
`default_nettype none

module cdtq_datapath #(
  parameter int unsigned QUEUE_DEPTH = cdtq_pkg::QueueDepthDefault
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  cdtq_pkg::ctrl_cmd_t  cmd_i,
  output cdtq_pkg::dp_stat_t   stat_o,
  input  wire                  op_i,
  input  wire  [1:0]           port_mask_i,
  input  wire                  drain_port_i,
  input  wire  [11:0]          std_id_i,
  input  wire  [28:0]          ext_id_i,
  input  wire                  is_ext_i,
  input  wire                  is_remote_i,
  input  wire  [3:0]           length_i,
  input  wire  [31:0]          payload_low_i,
  input  wire  [31:0]          payload_high_i,
  input  wire  [2:0]           mailbox_free_i,
  output logic [2:0]           status_o,
  output logic [1:0]           mailbox_o,
  output logic [31:0]          id_word_o,
  output logic [3:0]           length_word_o,
  output logic [31:0]          data_low_word_o,
  output logic [31:0]          data_high_word_o,
  output logic [1:0]           overflow_flag_o,
  output logic [15:0]          overflow_total_o
);

  localparam int unsigned IdxW = $clog2(QUEUE_DEPTH);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(QUEUE_DEPTH - 1);

  logic [IdxW-1:0] wptr_q [2];
  logic [IdxW-1:0] wptr_d [2];
  logic [IdxW-1:0] rptr_q [2];
  logic [IdxW-1:0] rptr_d [2];
  logic [1:0]      mark_q, mark_d;
  logic [15:0]     cnt_q [2];
  logic [15:0]     cnt_d [2];
  logic [1:0]      wr_en;
  cdtq_pkg::entry_t wr_entry;
  cdtq_pkg::entry_t rdata_q [2];

  logic       dport_q, dport_d;
  logic [2:0] mfree_q, mfree_d;

  logic [2:0]  status_q, status_d;
  logic [1:0]  mbox_q, mbox_d;
  logic [31:0] idw_q, idw_d;
  logic [3:0]  lenw_q, lenw_d;
  logic [31:0] dlo_q, dlo_d;
  logic [31:0] dhi_q, dhi_d;
  logic [1:0]  flag_q, flag_d;
  logic [15:0] total_q, total_d;

  function automatic logic [IdxW-1:0] ring_next(input logic [IdxW-1:0] idx);
    ring_next = (idx == LastIdx) ? '0 : idx + IdxW'(1);
  endfunction

  assign wr_entry = '{
    dlc:     length_i,
    rtr:     is_remote_i,
    ide:     is_ext_i,
    ext_id:  ext_id_i,
    std_id:  std_id_i[10:0],
    data_hi: payload_high_i,
    data_lo: payload_low_i
  };

  assign stat_o.in_drain = (op_i == cdtq_pkg::OP_DRAIN);
  assign stat_o.in_empty = (rptr_q[drain_port_i] == wptr_q[drain_port_i]);

  for (genvar p = 0; p < 2; p++) begin : g_queue
    cdtq_pkg::entry_t mem [QUEUE_DEPTH];

    always_ff @(posedge clk_i) begin
      if (wr_en[p]) begin
        mem[wptr_q[p]] <= wr_entry;
      end
      rdata_q[p] <= mem[rptr_q[p]];
    end
  end

  always_comb begin
    logic             sel;
    logic             enq_ok;
    logic [IdxW-1:0]  nxt;
    cdtq_pkg::entry_t head;

    sel    = 1'b0;
    nxt    = '0;
    head   = rdata_q[dport_q];
    enq_ok = (std_id_i <= cdtq_pkg::StdIdMax) && (length_i <= cdtq_pkg::DlcMax);
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    mark_d = mark_q;
    cnt_d  = cnt_q;
    wr_en  = 2'b00;
    dport_d = dport_q;
    mfree_d = mfree_q;
    status_d = status_q;
    mbox_d   = mbox_q;
    idw_d    = idw_q;
    lenw_d   = lenw_q;
    dlo_d    = dlo_q;
    dhi_d    = dhi_q;
    flag_d   = flag_q;
    total_d  = total_q;

    if (cmd_i.accept) begin
      dport_d = drain_port_i;
      mfree_d = mailbox_free_i;
      mbox_d  = '0;
      idw_d   = '0;
      lenw_d  = '0;
      dlo_d   = '0;
      dhi_d   = '0;
      if (op_i == cdtq_pkg::OP_ENQUEUE) begin
        sel = (port_mask_i == 2'b10);
        if (enq_ok) begin
          for (int p = 0; p < 2; p++) begin
            if (port_mask_i[p]) begin
              wr_en[p]  = 1'b1;
              nxt       = ring_next(wptr_q[p]);
              wptr_d[p] = nxt;
              if (nxt == rptr_q[p]) begin
                mark_d[p] = 1'b1;
                if (cnt_q[p] != cdtq_pkg::CountMax) begin
                  cnt_d[p] = cnt_q[p] + 16'd1;
                end
              end
            end
          end
          status_d = cdtq_pkg::STATUS_QUEUED;
        end else begin
          status_d = cdtq_pkg::STATUS_REJECTED;
        end
        flag_d  = mark_d;
        total_d = cnt_d[sel];
      end else if (stat_o.in_empty) begin
        sel      = drain_port_i;
        status_d = cdtq_pkg::STATUS_EMPTY;
        flag_d   = mark_q;
        total_d  = cnt_q[sel];
      end
    end

    if (cmd_i.finish) begin
      sel = dport_q;
      if ((head.std_id == '0) && (head.ext_id == '0)) begin
        status_d    = cdtq_pkg::STATUS_NULL;
        mark_d[sel] = 1'b0;
        rptr_d[sel] = ring_next(rptr_q[sel]);
      end else if (mfree_q == 3'b000) begin
        status_d = cdtq_pkg::STATUS_BUSY;
      end else begin
        status_d = cdtq_pkg::STATUS_SENT;
        mbox_d   = mfree_q[0] ? 2'd0 : (mfree_q[1] ? 2'd1 : 2'd2);
        if (head.ide) begin
          idw_d = {head.ext_id, 3'b100};
        end else begin
          idw_d = {head.std_id, 21'd0};
        end
        idw_d       = idw_d | {30'd0, head.rtr, 1'b1};
        lenw_d      = head.dlc;
        dlo_d       = head.data_lo;
        dhi_d       = head.data_hi;
        mark_d[sel] = 1'b0;
        rptr_d[sel] = ring_next(rptr_q[sel]);
      end
      flag_d  = mark_d;
      total_d = cnt_q[sel];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '{default: '0};
      rptr_q <= '{default: '0};
      mark_q <= '0;
      cnt_q  <= '{default: '0};
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      mark_q <= mark_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dport_q  <= dport_d;
    mfree_q  <= mfree_d;
    status_q <= status_d;
    mbox_q   <= mbox_d;
    idw_q    <= idw_d;
    lenw_q   <= lenw_d;
    dlo_q    <= dlo_d;
    dhi_q    <= dhi_d;
    flag_q   <= flag_d;
    total_q  <= total_d;
  end

  assign status_o         = status_q;
  assign mailbox_o        = mbox_q;
  assign id_word_o        = idw_q;
  assign length_word_o    = lenw_q;
  assign data_low_word_o  = dlo_q;
  assign data_high_word_o = dhi_q;
  assign overflow_flag_o  = flag_q;
  assign overflow_total_o = total_q;

endmodule

`default_nettype wire

[rtl/cdtq_ctrl.sv]
// Controller: request sequencing state machine of the transmit queue block.
`default_nettype none

module cdtq_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  input  cdtq_pkg::dp_stat_t   stat_i,
  output cdtq_pkg::ctrl_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_OUT  = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);
  assign accept      = in_valid_i && in_ready_o;

  assign cmd_o.accept = accept;
  assign cmd_o.finish = (state_q == ST_READ);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (stat_i.in_drain && !stat_i.in_empty) begin
            state_d = ST_READ;
          end else begin
            state_d = ST_OUT;
          end
        end
      end
      ST_READ: begin
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire
